FILE: design/dac_pkg.sv
// Shared types and constants for the distinct address counter.
package dac_pkg;

	// Fixed field widths.
	localparam int ADDR_W      = 48;
	localparam int RSSI_W      = 8;
	localparam int COUNT_OUT_W = 9;

	// Minimum strength after reset, in dBm.
	localparam logic signed [RSSI_W-1:0] MIN_STRENGTH_RESET = -8'sd90;

	// Controller states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EVAL   = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the accepted item
		logic report;    // result with current count and no flags
		logic clear;     // empty the table
		logic start;     // toggle indicator, rewind the scan
		logic search;    // read the next table entry
		logic hit_done;  // address found in the table
		logic miss_done; // address absent: append or flag full
		logic emit;      // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mode;      // held item is an end of sweep
		logic pass;      // held frame meets the minimum strength
		logic hit;       // compared entry matches the held address
		logic exhausted; // every stored entry has been compared
	} sts_t;

endpackage

FILE: design/dac_if.sv
// Handshake channels for frames, results and the configuration register.
interface dac_in_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic signed [dac_pkg::RSSI_W-1:0] signal_strength;
	logic [dac_pkg::ADDR_W-1:0]       source_address;

	modport source (output valid, mode, signal_strength, source_address, input ready);
	modport sink (input valid, mode, signal_strength, source_address, output ready);
endinterface

interface dac_out_if;
	logic                              valid;
	logic                              ready;
	logic                              accepted;
	logic                              is_new;
	logic                              table_full;
	logic [dac_pkg::COUNT_OUT_W-1:0]   distinct_count;
	logic                              indicator;

	modport source (output valid, accepted, is_new, table_full, distinct_count, indicator,
		input ready);
	modport sink (input valid, accepted, is_new, table_full, distinct_count, indicator,
		output ready);
endinterface

interface dac_cfg_if;
	logic                             valid;
	logic                             ready;
	logic signed [dac_pkg::RSSI_W-1:0] min_strength;

	modport source (output valid, min_strength, input ready);
	modport sink (input valid, min_strength, output ready);
endinterface

FILE: design/dac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dac_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: design/dac_ctrl.sv
// Controller state machine: sequences capture, table scan and result hand-off.
module dac_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	input  dac_pkg::sts_t   sts,
	output dac_pkg::cmd_t   cmd,
	output logic            in_ready,
	output logic            out_valid
);
	dac_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			dac_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = dac_pkg::ST_EVAL;
				end
			end
			dac_pkg::ST_EVAL: begin
				if (sts.mode) begin
					cmd.report = 1'b1;
					cmd.clear  = 1'b1;
					state_d    = dac_pkg::ST_EMIT;
				end else if (!sts.pass) begin
					cmd.report = 1'b1;
					state_d    = dac_pkg::ST_EMIT;
				end else begin
					cmd.start = 1'b1;
					state_d   = dac_pkg::ST_SEARCH;
				end
			end
			dac_pkg::ST_SEARCH: begin
				if (sts.hit) begin
					cmd.hit_done = 1'b1;
					state_d      = dac_pkg::ST_EMIT;
				end else if (sts.exhausted) begin
					cmd.miss_done = 1'b1;
					state_d       = dac_pkg::ST_EMIT;
				end else begin
					cmd.search = 1'b1;
				end
			end
			dac_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = dac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dac_pkg::ST_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dac_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == dac_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
endmodule

FILE: design/dac_datapath.sv
// Datapath: held item, strength register, address table, scan index and result registers.
module dac_datapath #(
	parameter int CAPACITY = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dac_pkg::cmd_t                       cmd,
	output dac_pkg::sts_t                       sts,
	input  logic                                cfg_we,
	input  logic signed [dac_pkg::RSSI_W-1:0]   cfg_min_strength,
	input  logic                                in_mode,
	input  logic signed [dac_pkg::RSSI_W-1:0]   in_strength,
	input  logic [dac_pkg::ADDR_W-1:0]          in_address,
	output logic                                out_accepted,
	output logic                                out_is_new,
	output logic                                out_table_full,
	output logic [dac_pkg::COUNT_OUT_W-1:0]     out_distinct_count,
	output logic                                out_indicator
);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic signed [dac_pkg::RSSI_W-1:0] min_strength_q;
	logic                              mode_q;
	logic signed [dac_pkg::RSSI_W-1:0] strength_q;
	logic [dac_pkg::ADDR_W-1:0]        address_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  idx_q;
	logic                              pend_s1;
	logic                              indicator_q;
	logic [dac_pkg::ADDR_W-1:0]        rdata;
	logic                              room;
	logic                              append;

	// Result held until the output register is free.
	logic                              res_accepted_q;
	logic                              res_is_new_q;
	logic                              res_full_q;
	logic [CNT_W-1:0]                  res_count_q;
	logic                              res_indicator_q;

	// Output register.
	logic                              out_accepted_q;
	logic                              out_is_new_q;
	logic                              out_full_q;
	logic [dac_pkg::COUNT_OUT_W-1:0]   out_count_q;
	logic                              out_indicator_q;

	assign room   = (count_q < CAP_CNT);
	assign append = cmd.miss_done && room;

	// Address table: appended at the fill count, scanned from entry zero.
	dac_ram #(
		.WIDTH (dac_pkg::ADDR_W),
		.DEPTH (CAPACITY)
	) u_table (
		.clk   (clk),
		.we    (append),
		.waddr (count_q[AW-1:0]),
		.wdata (address_q),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	// Status toward the controller.
	always_comb begin
		sts.mode      = mode_q;
		sts.pass      = (strength_q >= min_strength_q);
		sts.hit       = pend_s1 && (rdata == address_q);
		sts.exhausted = !pend_s1 && (idx_q == count_q);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_strength_q <= dac_pkg::MIN_STRENGTH_RESET;
		end else if (cfg_we) begin
			min_strength_q <= cfg_min_strength;
		end
	end

	// Held item.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= in_mode;
			strength_q <= in_strength;
			address_q  <= in_address;
		end
	end

	// Fill count, indicator and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			indicator_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.start) begin
				indicator_q <= ~indicator_q;
				idx_q       <= '0;
				pend_s1     <= 1'b0;
			end else if (cmd.search) begin
				pend_s1 <= (idx_q != count_q);
				if (idx_q != count_q) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
		end
	end

	// Result capture.
	always_ff @(posedge clk) begin
		if (cmd.report) begin
			res_accepted_q  <= 1'b0;
			res_is_new_q    <= 1'b0;
			res_full_q      <= 1'b0;
			res_count_q     <= count_q;
			res_indicator_q <= indicator_q;
		end else if (cmd.hit_done) begin
			res_accepted_q  <= 1'b1;
			res_is_new_q    <= 1'b0;
			res_full_q      <= 1'b0;
			res_count_q     <= count_q;
			res_indicator_q <= indicator_q;
		end else if (cmd.miss_done) begin
			res_accepted_q  <= 1'b1;
			res_is_new_q    <= room;
			res_full_q      <= !room;
			res_count_q     <= room ? count_q + CNT_W'(1) : count_q;
			res_indicator_q <= indicator_q;
		end
	end

	// Output register, loaded when the previous result has been taken.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_accepted_q  <= res_accepted_q;
			out_is_new_q    <= res_is_new_q;
			out_full_q      <= res_full_q;
			out_count_q     <= dac_pkg::COUNT_OUT_W'(res_count_q);
			out_indicator_q <= res_indicator_q;
		end
	end

	assign out_accepted       = out_accepted_q;
	assign out_is_new         = out_is_new_q;
	assign out_table_full     = out_full_q;
	assign out_distinct_count = out_count_q;
	assign out_indicator      = out_indicator_q;
endmodule

FILE: design/distinct_address_counter.sv
// Distinct sender address counter, top level. An accepted frame is scanned against the N
// addresses currently stored: the table lives in one RAM with a single registered read
// port, and the scan compares one stored address per cycle, stopping early on a match.
// End-of-sweep items and frames below the minimum strength skip the scan. One item is in
// work at a time; a new item is taken while the previous result still waits in the output
// register.
// The table needs no clearing after reset, since only entries below the fill count are read.
module distinct_address_counter #(
	parameter int CAPACITY = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	dac_in_if.sink       frame_in,
	dac_out_if.source    result_out,
	dac_cfg_if.sink      cfg
);
	dac_pkg::cmd_t cmd;
	dac_pkg::sts_t sts;

	// The strength register is always ready for a write.
	assign cfg.ready = 1'b1;

	// Controller.
	dac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame_in.valid),
		.out_ready (result_out.ready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (frame_in.ready),
		.out_valid (result_out.valid)
	);

	// Datapath.
	dac_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg.valid),
		.cfg_min_strength   (cfg.min_strength),
		.in_mode            (frame_in.mode),
		.in_strength        (frame_in.signal_strength),
		.in_address         (frame_in.source_address),
		.out_accepted       (result_out.accepted),
		.out_is_new         (result_out.is_new),
		.out_table_full     (result_out.table_full),
		.out_distinct_count (result_out.distinct_count),
		.out_indicator      (result_out.indicator)
	);

`ifndef SYNTHESIS
	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!result_out.valid || result_out.ready))
		else $error("result overwritten while still pending");

	// At most one way to finish an item at a time.
	a_one_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.report, cmd.hit_done, cmd.miss_done}))
		else $error("conflicting result commands");

	// Only one item is in work: input closes right after an item is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_in.valid && frame_in.ready) |=> !frame_in.ready)
		else $error("second item taken while one is in work");

	// The scan advances only while no decision is available.
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search |-> (!sts.hit && !sts.exhausted))
		else $error("scan stepped past a decision");
`endif
endmodule

FILE: tb/tb.sv
// Self-checking testbench for the distinct address counter, with its own scoreboard model.
`timescale 1ns / 100ps

module tb;
	localparam int ADDR_W      = dac_pkg::ADDR_W;
	localparam int RSSI_W      = dac_pkg::RSSI_W;
	localparam int COUNT_OUT_W = dac_pkg::COUNT_OUT_W;

	localparam logic signed [RSSI_W-1:0] MIN_STRENGTH_RESET = dac_pkg::MIN_STRENGTH_RESET;

	localparam int TABLE_DEPTH  = 256;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int REPORT_MAX   = 10;
	localparam int LONG_HOLD    = 2000;

	localparam logic MODE_FRAME     = 1'b0;
	localparam logic MODE_SWEEP_END = 1'b1;

	localparam logic signed [RSSI_W-1:0] RSSI_MIN = -8'sd128;
	localparam logic signed [RSSI_W-1:0] RSSI_MAX = 8'sd127;

	typedef enum int {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_RARE} stall_style_t;

	typedef struct packed {
		logic                      mode;
		logic signed [RSSI_W-1:0]  signal_strength;
		logic [ADDR_W-1:0]         source_address;
	} frame_t;

	typedef struct packed {
		logic                      accepted;
		logic                      is_new;
		logic                      table_full;
		logic [COUNT_OUT_W-1:0]    distinct_count;
		logic                      indicator;
	} tally_t;

	logic clk;
	logic arst_n;

	dac_in_if  frame_if ();
	dac_out_if result_if ();
	dac_cfg_if cfg_if ();

	distinct_address_counter #(.CAPACITY(TABLE_DEPTH)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_if),
		.result_out (result_if),
		.cfg        (cfg_if)
	);

	// Scoreboard copy of the block state.
	logic [ADDR_W-1:0]        seen_table [TABLE_DEPTH];
	int                       seen_count;
	logic                     blink_level;
	logic signed [RSSI_W-1:0] strength_floor;

	frame_t frame_q[$];
	tally_t tally_due_q[$];

	int   cycle_count;
	int   results_seen;
	int   mismatch_count;
	logic item_went;

	int           gap_left;
	int           burst_left;
	int           hold_left;
	int           holds_done;
	int           style_left;
	int           stall_tick;
	stall_style_t stall_style;

	// Clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the result of one frame or sweep end and update the model state.
	function automatic tally_t tally_frame(frame_t f);
		tally_t r;
		logic   found;
		r = '0;
		if (f.mode == MODE_SWEEP_END) begin
			r.distinct_count = seen_count[COUNT_OUT_W-1:0];
			seen_count = 0;
		end else begin
			if (f.signal_strength >= strength_floor) begin
				r.accepted = 1'b1;
				blink_level = ~blink_level;
				found = 1'b0;
				for (int i = 0; i < seen_count; i++)
					if (seen_table[i] == f.source_address)
						found = 1'b1;
				if (!found) begin
					if (seen_count < TABLE_DEPTH) begin
						seen_table[seen_count] = f.source_address;
						seen_count++;
						r.is_new = 1'b1;
					end else begin
						r.table_full = 1'b1;
					end
				end
			end
			r.distinct_count = seen_count[COUNT_OUT_W-1:0];
		end
		r.indicator = blink_level;
		return r;
	endfunction

	// Sample all handshakes at the rising edge: register writes, accepted items and results.
	always @(posedge clk) begin
		frame_t got;
		tally_t want;
		tally_t seen;
		cycle_count++;
		item_went = 1'b0;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				strength_floor = cfg_if.min_strength;
			if (frame_if.valid && frame_if.ready) begin
				got.mode            = frame_if.mode;
				got.signal_strength = frame_if.signal_strength;
				got.source_address  = frame_if.source_address;
				tally_due_q.push_back(tally_frame(got));
				item_went = 1'b1;
			end
			if (result_if.valid && result_if.ready) begin
				seen.accepted       = result_if.accepted;
				seen.is_new         = result_if.is_new;
				seen.table_full     = result_if.table_full;
				seen.distinct_count = result_if.distinct_count;
				seen.indicator      = result_if.indicator;
				results_seen++;
				if (tally_due_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("result %0d arrived with nothing outstanding", results_seen);
				end else begin
					want = tally_due_q.pop_front();
					if (seen !== want) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display({"result %0d: expected acc=%0b new=%0b full=%0b count=%0d ind=%0b,",
								" got acc=%0b new=%0b full=%0b count=%0d ind=%0b"}, results_seen,
								want.accepted, want.is_new, want.table_full, want.distinct_count,
								want.indicator, seen.accepted, seen.is_new, seen.table_full,
								seen.distinct_count, seen.indicator);
					end
				end
			end
		end
	end

	// Frame driver: bursts of items from the pending queue with random gaps between bursts.
	always @(negedge clk) begin
		frame_t nxt;
		if (!arst_n) begin
			frame_if.valid <= 1'b0;
		end else if (!frame_if.valid || item_went) begin
			if (gap_left > 0) begin
				gap_left--;
				frame_if.valid <= 1'b0;
			end else if (frame_q.size() > 0) begin
				nxt = frame_q.pop_front();
				frame_if.valid           <= 1'b1;
				frame_if.mode            <= nxt.mode;
				frame_if.signal_strength <= nxt.signal_strength;
				frame_if.source_address  <= nxt.source_address;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end
			end else begin
				frame_if.valid <= 1'b0;
			end
		end
	end

	// Result receiver: changing stall patterns, plus two long hold-offs that back up the block.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_if.ready <= 1'b0;
		end else if (holds_done < 2 && results_seen >= 400 + holds_done * 900) begin
			holds_done++;
			hold_left = LONG_HOLD;
			result_if.ready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				stall_style = stall_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(50, 400);
			end else begin
				style_left--;
			end
			stall_tick++;
			case (stall_style)
				STALL_NONE: begin
					result_if.ready <= 1'b1;
				end
				STALL_COIN: begin
					result_if.ready <= 1'($urandom_range(0, 1));
				end
				STALL_THIRD: begin
					result_if.ready <= (stall_tick % 3 == 0);
				end
				default: begin
					result_if.ready <= ($urandom_range(0, 7) != 0);
				end
			endcase
		end
	end

	// Watchdog.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("distinct_address_counter: mismatch");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: w = '0;
			1: w = '1;
			default: begin
			end
		endcase
		return w[ADDR_W-1:0];
	endfunction

	// Strength near the threshold most of the time, anywhere in range otherwise.
	function automatic logic signed [RSSI_W-1:0] pick_strength(logic signed [RSSI_W-1:0] floor);
		int v;
		if ($urandom_range(0, 2) != 0) begin
			v = int'(floor) + int'($urandom_range(0, 8)) - 4;
			if (v > 127)
				v = 127;
			if (v < -128)
				v = -128;
			return v[RSSI_W-1:0];
		end
		return RSSI_W'($urandom_range(0, 255));
	endfunction

	task automatic push_frame(logic mode, logic signed [RSSI_W-1:0] strength,
		logic [ADDR_W-1:0] addr);
		frame_t f;
		f.mode            = mode;
		f.signal_strength = strength;
		f.source_address  = addr;
		frame_q.push_back(f);
	endtask

	// Sweeps over small address pools, with some fresh addresses and early sweep ends as noise.
	task automatic plan_sweeps(int count, logic signed [RSSI_W-1:0] floor);
		logic [ADDR_W-1:0] pool[$];
		int left;
		int sweep_len;
		int pick;
		left = count;
		while (left > 0) begin
			pool.delete();
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 8))
				pool.push_back(rand_addr());
			sweep_len = $urandom_range(1, 40);
			if (sweep_len > left - 1)
				sweep_len = left - 1;
			repeat (sweep_len) begin
				pick = $urandom_range(0, 15);
				if (pick < 12)
					push_frame(MODE_FRAME, pick_strength(floor),
						pool[$urandom_range(0, pool.size() - 1)]);
				else if (pick < 15)
					push_frame(MODE_FRAME, RSSI_W'($urandom_range(0, 255)), rand_addr());
				else
					push_frame(MODE_SWEEP_END, RSSI_W'($urandom_range(0, 255)), rand_addr());
			end
			push_frame(MODE_SWEEP_END, RSSI_W'($urandom_range(0, 255)), rand_addr());
			left -= sweep_len + 1;
		end
	endtask

	// One sweep that fills the table, overflows it and revisits stored addresses.
	task automatic plan_fill();
		logic [ADDR_W-1:0] kept[$];
		logic [ADDR_W-1:0] a;
		for (int i = 0; i < TABLE_DEPTH + 8; i++) begin
			a = rand_addr();
			a[8:0] = i[8:0];
			push_frame(MODE_FRAME, RSSI_W'($urandom_range(0, 255)), a);
			if (i < TABLE_DEPTH)
				kept.push_back(a);
			if ($urandom_range(0, 7) == 0)
				push_frame(MODE_FRAME, RSSI_W'($urandom_range(0, 255)),
					kept[$urandom_range(0, kept.size() - 1)]);
		end
		push_frame(MODE_FRAME, RSSI_W'($urandom_range(0, 255)), kept[TABLE_DEPTH - 1]);
		push_frame(MODE_SWEEP_END, RSSI_W'($urandom_range(0, 255)), rand_addr());
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (frame_q.size() != 0 || frame_if.valid || tally_due_q.size() != 0);
	endtask

	task automatic set_floor(logic signed [RSSI_W-1:0] value);
		@(negedge clk);
		cfg_if.valid        <= 1'b1;
		cfg_if.min_strength <= value;
		do
			@(posedge clk);
		while (!(cfg_if.valid && cfg_if.ready));
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Main sequence: reset, directed items at the reset threshold, then random phases.
	initial begin
		logic signed [RSSI_W-1:0] floors [6];
		clk                      = 1'b0;
		arst_n                   = 1'b0;
		frame_if.valid           = 1'b0;
		frame_if.mode            = MODE_FRAME;
		frame_if.signal_strength = '0;
		frame_if.source_address  = '0;
		result_if.ready          = 1'b0;
		cfg_if.valid             = 1'b0;
		cfg_if.min_strength      = '0;
		seen_count               = 0;
		blink_level              = 1'b0;
		strength_floor           = MIN_STRENGTH_RESET;
		cycle_count              = 0;
		results_seen             = 0;
		mismatch_count           = 0;
		item_went                = 1'b0;
		gap_left                 = 0;
		burst_left               = 1;
		hold_left                = 0;
		holds_done               = 0;
		style_left               = 0;
		stall_tick               = 0;
		stall_style              = STALL_NONE;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items: threshold edges, extreme fields, hits, misses and sweep ends.
		push_frame(MODE_SWEEP_END, RSSI_W'($urandom_range(0, 255)), rand_addr());
		push_frame(MODE_FRAME, -8'sd90, 48'h0);
		push_frame(MODE_FRAME, -8'sd91, 48'h1);
		push_frame(MODE_FRAME, RSSI_MIN, 48'hFFFF_FFFF_FFFF);
		push_frame(MODE_FRAME, RSSI_MAX, 48'hFFFF_FFFF_FFFF);
		push_frame(MODE_FRAME, 8'sd0, 48'h0);
		push_frame(MODE_FRAME, -8'sd1, 48'hAAAA_AAAA_AAAA);
		push_frame(MODE_FRAME, 8'sh55, 48'h5555_5555_5555);
		push_frame(MODE_FRAME, 8'shAA, 48'hFFFF_FFFF_FFFF);
		push_frame(MODE_FRAME, -8'sd90, 48'h5555_5555_5555);
		push_frame(MODE_FRAME, -8'sd91, 48'h1234_5678_9ABC);
		push_frame(MODE_FRAME, -8'sd89, 48'h1234_5678_9ABC);
		push_frame(MODE_SWEEP_END, RSSI_MAX, 48'hFFFF_FFFF_FFFF);
		push_frame(MODE_SWEEP_END, RSSI_MIN, 48'h0);
		push_frame(MODE_FRAME, -8'sd90, 48'h0);
		push_frame(MODE_FRAME, -8'sd91, 48'hAAAA_AAAA_AAAA);
		push_frame(MODE_SWEEP_END, RSSI_MIN, 48'h0);
		wait_drained();

		// Lowest threshold first, so that the table fill sees every frame counted.
		set_floor(RSSI_MIN);
		plan_fill();
		wait_drained();

		floors[0] = RSSI_MIN;
		floors[1] = RSSI_MAX;
		floors[2] = RSSI_W'($urandom_range(0, 255));
		floors[3] = 8'sd0;
		floors[4] = RSSI_W'($urandom_range(0, 255));
		floors[5] = MIN_STRENGTH_RESET;
		for (int p = 0; p < 6; p++) begin
			if (p > 0)
				set_floor(floors[p]);
			plan_sweeps(265, floors[p]);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && tally_due_q.size() == 0)
			$display("distinct_address_counter: match");
		else
			$display("distinct_address_counter: mismatch");
		$finish;
	end

endmodule
